/* rtl/ttfd_pkg.sv */
package ttfd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TAN_W      = 18;
    localparam int TICK_W     = 16;
    localparam int COOL_W     = 20;
    localparam int ACC_W      = 16;
    localparam int NOW_W      = 32;
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 32;
    localparam int PROD_W     = 50;
    localparam int Q16_SHIFT  = 16;
    localparam int DIFF_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TURN_TAN_SQ    = 3'd0,
        REG_CENTRE_TAN_SQ  = 3'd1,
        REG_FALL_TAN_SQ    = 3'd2,
        REG_BLINK_TICKS    = 3'd3,
        REG_COOLDOWN_TICKS = 3'd4,
        REG_SHOT_SPACING   = 3'd5
    } t_reg_idx;

    localparam logic [TAN_W-1:0]  RST_TURN_TAN_SQ   = 18'd21845;
    localparam logic [TAN_W-1:0]  RST_CENTRE_TAN_SQ = 18'd4705;
    localparam logic [TAN_W-1:0]  RST_FALL_TAN_SQ   = 18'd65536;
    localparam logic [TICK_W-1:0] RST_BLINK_TICKS   = 16'd200;
    localparam logic [COOL_W-1:0] RST_COOLDOWN      = 20'd5000;
    localparam logic [TICK_W-1:0] RST_SHOT_SPACING  = 16'd500;

    typedef struct packed {
        logic [TAN_W-1:0]  turn_tan_sq;
        logic [TAN_W-1:0]  centre_tan_sq;
        logic [TAN_W-1:0]  fall_tan_sq;
        logic [TICK_W-1:0] blink_ticks;
        logic [COOL_W-1:0] cooldown_ticks;
        logic [TICK_W-1:0] shot_spacing_ticks;
    } t_cfg;

    // Classification of one sample, handed from the front to the back.
    typedef struct packed {
        logic read_ok;
        logic go_left;
        logic go_right;
        logic centre;
        logic fall;
    } t_cls;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SQUARE,
        FS_SUM,
        FS_MULT,
        FS_CMP
    } t_fstate;

endpackage

/* rtl/ttfd_in_if.sv */
interface ttfd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               sample_valid;
    logic [31:0]        now_ticks;

    modport source (
        output valid, accel_x, accel_y, accel_z, sample_valid, now_ticks,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, sample_valid, now_ticks,
        output ready
    );
endinterface

/* rtl/ttfd_out_if.sv */
interface ttfd_out_if;
    logic valid;
    logic ready;
    logic left_lamp;
    logic right_lamp;
    logic fall_signal;
    logic capture_busy;
    logic sensor_disabled;

    modport source (
        output valid, left_lamp, right_lamp, fall_signal, capture_busy, sensor_disabled,
        input  ready
    );
    modport sink (
        input  valid, left_lamp, right_lamp, fall_signal, capture_busy, sensor_disabled,
        output ready
    );
endinterface

/* rtl/ttfd_front.sv */
module ttfd_front
    import ttfd_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ttfd_in_if.sink              i_sample,
    input  t_cfg                 i_cfg,
    input  logic                 i_full,
    output logic                 o_push,
    output t_cls                 o_cls,
    output logic [TIME_BITS-1:0] o_now
);

    t_fstate r_state, n_state;

    logic signed [ACC_W-1:0] r_x, r_y, r_z;
    logic                    r_read_ok;
    logic [TIME_BITS-1:0]    r_now;

    logic [SQ_W-1:0]   r_x2, r_y2, r_z2;
    logic [SUM_W-1:0]  r_sy, r_h;
    logic [PROD_W-1:0] r_p_turn, r_p_centre, r_p_fall;

    logic signed [2*ACC_W-1:0] w_x2, w_y2, w_z2;
    logic [PROD_W-1:0]         w_lhs_x, w_lhs_h;
    logic                      w_accept, w_side_out, w_zero;

    assign w_accept = i_sample.valid && i_sample.ready;

    assign w_x2 = r_x * r_x;
    assign w_y2 = r_y * r_y;
    assign w_z2 = r_z * r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x       <= i_sample.accel_x;
            r_y       <= i_sample.accel_y;
            r_z       <= i_sample.accel_z;
            r_read_ok <= i_sample.sample_valid;
            r_now     <= i_sample.now_ticks[TIME_BITS-1:0];
        end
        r_x2       <= w_x2[SQ_W-1:0];
        r_y2       <= w_y2[SQ_W-1:0];
        r_z2       <= w_z2[SQ_W-1:0];
        r_sy       <= SUM_W'(r_y2) + SUM_W'(r_z2);
        r_h        <= SUM_W'(r_x2) + SUM_W'(r_y2);
        r_p_turn   <= PROD_W'(i_cfg.turn_tan_sq) * PROD_W'(r_sy);
        r_p_centre <= PROD_W'(i_cfg.centre_tan_sq) * PROD_W'(r_sy);
        r_p_fall   <= PROD_W'(i_cfg.fall_tan_sq) * PROD_W'(r_z2);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (i_sample.valid) begin
                    n_state = FS_SQUARE;
                end
            end
            FS_SQUARE: n_state = FS_SUM;
            FS_SUM:    n_state = FS_MULT;
            FS_MULT:   n_state = FS_CMP;
            FS_CMP: begin
                if (!i_full) begin
                    n_state = FS_IDLE;
                end
            end
            default:   n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        i_sample.ready = 1'b0;
        o_push         = 1'b0;
        case (r_state)
            FS_IDLE: i_sample.ready = 1'b1;
            FS_CMP:  o_push = !i_full;
            default: begin
                i_sample.ready = 1'b0;
                o_push         = 1'b0;
            end
        endcase
    end

    // Angle tests as squared tangents: x^2 * 2^16 against tan^2 * (y^2 + z^2).
    assign w_lhs_x    = PROD_W'({r_x2, {Q16_SHIFT{1'b0}}});
    assign w_lhs_h    = PROD_W'({r_h, {Q16_SHIFT{1'b0}}});
    assign w_side_out = w_lhs_x > r_p_turn;
    assign w_zero     = (r_x == '0) && (r_y == '0) && (r_z == '0);

    always_comb begin
        o_cls.read_ok  = r_read_ok;
        o_cls.go_left  = r_x[ACC_W-1] && w_side_out;
        o_cls.go_right = !r_x[ACC_W-1] && (r_x != '0) && w_side_out;
        // The all-zero vector counts as upright: centred whenever the band is open.
        o_cls.centre   = w_zero ? (i_cfg.centre_tan_sq != '0) : (w_lhs_x < r_p_centre);
        // With z at zero the product on the right is zero, so this reduces to h > 0.
        o_cls.fall     = r_z[ACC_W-1] || (w_lhs_h > r_p_fall);
    end

    assign o_now = r_now;

endmodule

/* rtl/ttfd_fifo.sv */
module ttfd_fifo
    import ttfd_pkg::*;
#(
    parameter int WIDTH = 37
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/ttfd_back.sv */
module ttfd_back
    import ttfd_pkg::*;
#(
    parameter int FAIL_LIMIT = 10,
    parameter int TIME_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    output logic                 o_pop,
    input  t_cls                 i_cls,
    input  logic [TIME_BITS-1:0] i_now,
    input  t_cfg                 i_cfg,
    ttfd_out_if.source           o_result
);

    localparam int CNT_W = $clog2(FAIL_LIMIT + 1);

    logic                 r_out_valid, n_out_valid;
    logic                 r_fall_sig, n_fall_sig;
    logic                 r_left_armed, n_left_armed;
    logic                 r_right_armed, n_right_armed;
    logic                 r_blink_phase, n_blink_phase;
    logic                 r_left_level, n_left_level;
    logic                 r_right_level, n_right_level;
    logic [TIME_BITS-1:0] r_last_toggle, n_last_toggle;
    logic                 r_capturing, n_capturing;
    logic [1:0]           r_shots, n_shots;
    logic [TIME_BITS-1:0] r_cap_start, n_cap_start;
    logic [TIME_BITS-1:0] r_cap_end, n_cap_end;
    logic [CNT_W-1:0]     r_fail_cnt, n_fail_cnt;
    logic                 r_disabled, n_disabled;

    logic [TIME_BITS-1:0] w_dt_blink, w_dt_cool, w_dt_shot;
    logic [TICK_W:0]      w_shot_goal;

    assign o_pop = !i_empty && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_fall_sig    <= 1'b0;
            r_left_armed  <= 1'b0;
            r_right_armed <= 1'b0;
            r_blink_phase <= 1'b0;
            r_left_level  <= 1'b0;
            r_right_level <= 1'b0;
            r_last_toggle <= '0;
            r_capturing   <= 1'b0;
            r_shots       <= '0;
            r_cap_start   <= '0;
            r_cap_end     <= '0;
            r_fail_cnt    <= '0;
            r_disabled    <= 1'b0;
        end else begin
            r_out_valid   <= n_out_valid;
            r_fall_sig    <= n_fall_sig;
            r_left_armed  <= n_left_armed;
            r_right_armed <= n_right_armed;
            r_blink_phase <= n_blink_phase;
            r_left_level  <= n_left_level;
            r_right_level <= n_right_level;
            r_last_toggle <= n_last_toggle;
            r_capturing   <= n_capturing;
            r_shots       <= n_shots;
            r_cap_start   <= n_cap_start;
            r_cap_end     <= n_cap_end;
            r_fail_cnt    <= n_fail_cnt;
            r_disabled    <= n_disabled;
        end
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_fall_sig    = r_fall_sig;
        n_left_armed  = r_left_armed;
        n_right_armed = r_right_armed;
        n_blink_phase = r_blink_phase;
        n_left_level  = r_left_level;
        n_right_level = r_right_level;
        n_last_toggle = r_last_toggle;
        n_capturing   = r_capturing;
        n_shots       = r_shots;
        n_cap_start   = r_cap_start;
        n_cap_end     = r_cap_end;
        n_fail_cnt    = r_fail_cnt;
        n_disabled    = r_disabled;
        w_dt_blink    = '0;
        w_dt_cool     = '0;
        w_dt_shot     = '0;
        w_shot_goal   = '0;

        if (o_pop) begin
            n_out_valid = 1'b1;
            n_fall_sig  = 1'b0;
            if (!r_disabled) begin
                if (!i_cls.read_ok) begin
                    if (r_fail_cnt >= CNT_W'(FAIL_LIMIT)) begin
                        n_disabled = 1'b1;
                    end else begin
                        n_fail_cnt = r_fail_cnt + 1'b1;
                    end
                end else begin
                    if (i_cls.go_left && !r_left_armed) begin
                        n_left_armed  = 1'b1;
                        n_right_armed = 1'b0;
                        n_last_toggle = i_now;
                    end else if (i_cls.go_right && !r_right_armed) begin
                        n_right_armed = 1'b1;
                        n_left_armed  = 1'b0;
                        n_last_toggle = i_now;
                    end else if (i_cls.centre) begin
                        if (r_left_armed || r_right_armed) begin
                            n_left_armed  = 1'b0;
                            n_right_armed = 1'b0;
                            n_left_level  = 1'b0;
                            n_right_level = 1'b0;
                        end
                    end

                    w_dt_blink = i_now - n_last_toggle;
                    if ((n_left_armed || n_right_armed) &&
                        (DIFF_W'(w_dt_blink) >= DIFF_W'(i_cfg.blink_ticks))) begin
                        n_blink_phase = !r_blink_phase;
                        n_last_toggle = i_now;
                        if (n_left_armed) begin
                            n_left_level  = n_blink_phase;
                            n_right_level = 1'b0;
                        end else begin
                            n_right_level = n_blink_phase;
                            n_left_level  = 1'b0;
                        end
                    end

                    w_dt_cool = i_now - r_cap_end;
                    if (i_cls.fall && !r_capturing &&
                        (DIFF_W'(w_dt_cool) >= DIFF_W'(i_cfg.cooldown_ticks))) begin
                        n_capturing   = 1'b1;
                        n_shots       = '0;
                        n_cap_start   = i_now;
                        n_left_armed  = 1'b0;
                        n_right_armed = 1'b0;
                        n_left_level  = 1'b0;
                        n_right_level = 1'b0;
                        n_fall_sig    = 1'b1;
                    end

                    // Shot k of a run is due k spacings after the start; only
                    // shot counts of zero and one reach the compare.
                    w_dt_shot   = i_now - n_cap_start;
                    w_shot_goal = n_shots[0] ? {i_cfg.shot_spacing_ticks, 1'b0}
                                             : {1'b0, i_cfg.shot_spacing_ticks};
                    if (n_capturing) begin
                        if (!n_shots[1] &&
                            (DIFF_W'(w_dt_shot) >= DIFF_W'(w_shot_goal))) begin
                            n_fall_sig = 1'b1;
                            n_shots    = n_shots + 1'b1;
                        end else if (n_shots[1]) begin
                            n_capturing = 1'b0;
                            n_cap_end   = i_now;
                        end
                    end
                end
            end
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // The state registers only move when a word is popped, which needs a free
    // output slot, so they double as the held result word.
    assign o_result.valid           = r_out_valid;
    assign o_result.left_lamp       = r_left_level;
    assign o_result.right_lamp      = r_right_level;
    assign o_result.fall_signal     = r_fall_sig;
    assign o_result.capture_busy    = r_capturing;
    assign o_result.sensor_disabled = r_disabled;

endmodule

/* rtl/tilt_turn_fall_detector_core.sv */
// Channel      Direction  Handshake            Word
// i_sample     in         valid / ready        accel_x/y/z, sample_valid, now_ticks
// o_result     out        valid / ready        lamps, fall_signal, capture_busy, disabled
// i_cfg_*      in         write enable only    register index, write data
//
// The front takes a new sample only once the last one is queued: squares, sums and
// threshold multiplies are registered in turn, and the compare state pushes the word.
// The back retires one queued word per cycle into the output register while that register is free or being taken.
// A result passes from the sample registers through the square, sum and product registers and the queue to the output.
// Reset is synchronous and active low and restores the register defaults.
// A stalled output fills the two-entry queue, after which the front holds off input.
module tilt_turn_fall_detector_core
    import ttfd_pkg::*;
#(
    parameter int FAIL_LIMIT = 10,
    parameter int TIME_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ttfd_in_if.sink               i_sample,
    ttfd_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CLS_W = $bits(t_cls);
    localparam int QW    = CLS_W + TIME_BITS;

    t_cfg r_cfg;

    logic                 w_push, w_pop, w_full, w_empty;
    t_cls                 w_front_cls, w_back_cls;
    logic [TIME_BITS-1:0] w_front_now, w_back_now;
    logic [QW-1:0]        w_q_in, w_q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_tan_sq        <= RST_TURN_TAN_SQ;
            r_cfg.centre_tan_sq      <= RST_CENTRE_TAN_SQ;
            r_cfg.fall_tan_sq        <= RST_FALL_TAN_SQ;
            r_cfg.blink_ticks        <= RST_BLINK_TICKS;
            r_cfg.cooldown_ticks     <= RST_COOLDOWN;
            r_cfg.shot_spacing_ticks <= RST_SHOT_SPACING;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TURN_TAN_SQ:    r_cfg.turn_tan_sq        <= i_cfg_wdata[TAN_W-1:0];
                REG_CENTRE_TAN_SQ:  r_cfg.centre_tan_sq      <= i_cfg_wdata[TAN_W-1:0];
                REG_FALL_TAN_SQ:    r_cfg.fall_tan_sq        <= i_cfg_wdata[TAN_W-1:0];
                REG_BLINK_TICKS:    r_cfg.blink_ticks        <= i_cfg_wdata[TICK_W-1:0];
                REG_COOLDOWN_TICKS: r_cfg.cooldown_ticks     <= i_cfg_wdata[COOL_W-1:0];
                REG_SHOT_SPACING:   r_cfg.shot_spacing_ticks <= i_cfg_wdata[TICK_W-1:0];
                default:            r_cfg                    <= r_cfg;
            endcase
        end
    end

    ttfd_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_cfg    (r_cfg),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_cls    (w_front_cls),
        .o_now    (w_front_now)
    );

    assign w_q_in = {w_front_cls, w_front_now};

    ttfd_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    assign w_back_cls = t_cls'(w_q_out[QW-1:TIME_BITS]);
    assign w_back_now = w_q_out[TIME_BITS-1:0];

    ttfd_back #(
        .FAIL_LIMIT (FAIL_LIMIT),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_cls    (w_back_cls),
        .i_now    (w_back_now),
        .i_cfg    (r_cfg),
        .o_result (o_result)
    );

endmodule

/* verif/testbench.sv */
module testbench;
    import ttfd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int FAIL_LIMIT_TB  = 10;
    localparam int TIME_BITS_TB   = 32;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTED   = 10;
    localparam longint Q16_ONE    = 65536;

    // Indexes past the last register, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
        logic                    ok;
        logic [NOW_W-1:0]        now;
    } t_sample;

    typedef struct packed {
        logic left_lamp;
        logic right_lamp;
        logic fall_signal;
        logic capture_busy;
        logic sensor_disabled;
    } t_status;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ttfd_in_if  sample_if ();
    ttfd_out_if result_if ();

    tilt_turn_fall_detector_core #(
        .FAIL_LIMIT (FAIL_LIMIT_TB),
        .TIME_BITS  (TIME_BITS_TB)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample    (sample_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow of the registers and of the detector state.
    t_cfg        cfg_shadow;
    logic        left_armed, right_armed, blink_phase, left_level, right_level;
    logic [31:0] last_toggle;
    logic        capturing;
    logic [1:0]  shots_done;
    logic [31:0] capture_start, capture_end;
    logic [3:0]  failed_reads;
    logic        blocked;

    t_status     expected_status_q[$];
    t_status     got_status, want_status;
    logic [31:0] tick_now;
    logic        tx_gap_en, rx_stall_en;
    int          error_count = 0;
    int          idle_cycles = 0;

    task automatic predict_status(input t_sample s);
        int          ax, ay, az;
        longint      x2, y2, z2, sy, h;
        logic        side_out, go_left, go_right, centre, fall, fall_sig;
        logic [31:0] now;
        fall_sig = 1'b0;
        if (!blocked) begin
            if (!s.ok) begin
                if (failed_reads >= FAIL_LIMIT_TB) begin
                    blocked = 1'b1;
                end else begin
                    failed_reads = failed_reads + 4'd1;
                end
            end else begin
                ax  = s.x;
                ay  = s.y;
                az  = s.z;
                now = s.now;
                x2  = longint'(ax) * ax;
                y2  = longint'(ay) * ay;
                z2  = longint'(az) * az;
                sy  = y2 + z2;
                h   = x2 + y2;
                side_out = (x2 * Q16_ONE) > (longint'(cfg_shadow.turn_tan_sq) * sy);
                go_left  = (ax < 0) && side_out;
                go_right = (ax > 0) && side_out;
                if (ax == 0 && ay == 0 && az == 0) begin
                    centre = (cfg_shadow.centre_tan_sq != '0);
                end else begin
                    centre = (x2 * Q16_ONE) < (longint'(cfg_shadow.centre_tan_sq) * sy);
                end
                if (az < 0) begin
                    fall = 1'b1;
                end else if (az == 0) begin
                    fall = (h > 0);
                end else begin
                    fall = (h * Q16_ONE) > (longint'(cfg_shadow.fall_tan_sq) * z2);
                end

                if (go_left && !left_armed) begin
                    left_armed  = 1'b1;
                    right_armed = 1'b0;
                    last_toggle = now;
                end else if (go_right && !right_armed) begin
                    right_armed = 1'b1;
                    left_armed  = 1'b0;
                    last_toggle = now;
                end else if (centre && (left_armed || right_armed)) begin
                    left_armed  = 1'b0;
                    right_armed = 1'b0;
                    left_level  = 1'b0;
                    right_level = 1'b0;
                end

                if ((left_armed || right_armed) &&
                    (now - last_toggle) >= 32'(cfg_shadow.blink_ticks)) begin
                    blink_phase = ~blink_phase;
                    last_toggle = now;
                    left_level  = left_armed ? blink_phase : 1'b0;
                    right_level = left_armed ? 1'b0 : blink_phase;
                end

                if (fall && !capturing &&
                    (now - capture_end) >= 32'(cfg_shadow.cooldown_ticks)) begin
                    capturing     = 1'b1;
                    shots_done    = 2'd0;
                    capture_start = now;
                    left_armed    = 1'b0;
                    right_armed   = 1'b0;
                    left_level    = 1'b0;
                    right_level   = 1'b0;
                    fall_sig      = 1'b1;
                end

                if (capturing) begin
                    if (shots_done < 2'd2 && (now - capture_start) >=
                        32'(cfg_shadow.shot_spacing_ticks) * (32'(shots_done) + 32'd1)) begin
                        fall_sig   = 1'b1;
                        shots_done = shots_done + 2'd1;
                    end else if (shots_done >= 2'd2) begin
                        capturing   = 1'b0;
                        capture_end = now;
                    end
                end
            end
        end
        expected_status_q.push_back('{left_level, right_level, fall_sig, capturing, blocked});
    endtask

    function automatic int idle_length(input logic enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [ACC_W-1:0] signed_in(input int lo, input int hi);
        int mag;
        mag = $urandom_range(hi, lo);
        return ($urandom_range(0, 1) != 0) ? ACC_W'(-mag) : ACC_W'(mag);
    endfunction

    function automatic logic signed [ACC_W-1:0] corner_value();
        case ($urandom_range(0, 4))
            0: return 16'sd0;
            1: return 16'sd1;
            2: return -16'sd1;
            3: return 16'sh7FFF;
            default: return 16'sh8000;
        endcase
    endfunction

    // Valid goes high at the falling edge and stays high until the word is taken.
    task automatic send_sample(input t_sample s);
        @(negedge clk);
        sample_if.valid        = 1'b1;
        sample_if.accel_x      = s.x;
        sample_if.accel_y      = s.y;
        sample_if.accel_z      = s.z;
        sample_if.sample_valid = s.ok;
        sample_if.now_ticks    = s.now;
        do @(posedge clk); while (sample_if.ready !== 1'b1);
        predict_status(s);
    endtask

    task automatic send_vector(input int x, input int y, input int z, input logic ok,
                               input logic [31:0] now);
        t_sample s;
        s.x   = ACC_W'(x);
        s.y   = ACC_W'(y);
        s.z   = ACC_W'(z);
        s.ok  = ok;
        s.now = now;
        send_sample(s);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            sample_if.valid = 1'b0;
        end
    endtask

    // Drop valid, wait for every outstanding result and let the pipeline empty.
    task automatic settle_idle();
        idle_sender(1);
        wait (expected_status_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        case (idx)
            REG_TURN_TAN_SQ:    cfg_shadow.turn_tan_sq        = data[TAN_W-1:0];
            REG_CENTRE_TAN_SQ:  cfg_shadow.centre_tan_sq      = data[TAN_W-1:0];
            REG_FALL_TAN_SQ:    cfg_shadow.fall_tan_sq        = data[TAN_W-1:0];
            REG_BLINK_TICKS:    cfg_shadow.blink_ticks        = data[TICK_W-1:0];
            REG_COOLDOWN_TICKS: cfg_shadow.cooldown_ticks     = data[COOL_W-1:0];
            REG_SHOT_SPACING:   cfg_shadow.shot_spacing_ticks = data[TICK_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic make_random_sample(output t_sample s);
        int pick, step;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            // Roughly level.
            s.x = signed_in(0, 2000);
            s.y = signed_in(0, 2000);
            s.z = ACC_W'($urandom_range(8000, 16383));
        end else if (pick < 48) begin
            // Leaning to one side, enough to arm a blinker at most settings.
            s.x = signed_in(3000, 20000);
            s.y = signed_in(0, 3000);
            s.z = ACC_W'($urandom_range(4000, 16383));
        end else if (pick < 62) begin
            s.x = signed_in(0, 16384);
            s.y = signed_in(0, 16384);
            s.z = signed_in(0, 16384);
        end else if (pick < 70) begin
            // Small sideways tilt around the centre band limit.
            s.x = signed_in(0, 4000);
            s.y = signed_in(0, 1000);
            s.z = ACC_W'($urandom_range(10000, 16383));
        end else if (pick < 92) begin
            s.x = ACC_W'($urandom);
            s.y = ACC_W'($urandom);
            s.z = ACC_W'($urandom);
        end else begin
            s.x = corner_value();
            s.y = corner_value();
            s.z = corner_value();
        end
        // Failed reads are never cleared, so keep well clear of the limit here.
        s.ok = !($urandom_range(0, 49) == 0 && failed_reads < FAIL_LIMIT_TB - 3);

        step = $urandom_range(0, 99);
        if (step >= 97) begin
            tick_now = tick_now + $urandom;
        end else if (step >= 85) begin
            tick_now = tick_now + 32'($urandom_range(150, 3000));
        end else if (step >= 5) begin
            tick_now = tick_now + 32'($urandom_range(1, 150));
        end
        s.now = tick_now;
    endtask

    task automatic run_random_traffic(input int count);
        t_sample s;
        repeat (count) begin
            make_random_sample(s);
            send_sample(s);
            idle_sender(idle_length(tx_gap_en));
        end
    endtask

    task automatic test_directed_cases();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b1;
        send_vector(0, 0, 0, 1'b1, 32'd0);
        send_vector(-32768, 0, 0, 1'b1, 32'd100);
        send_vector(-32768, 0, 0, 1'b1, 32'd400);
        send_vector(32767, -32768, 32767, 1'b1, 32'd450);
        send_vector(32767, 100, 1000, 1'b1, 32'd700);
        send_vector(0, 100, 16384, 1'b1, 32'd800);
        send_vector(0, 0, -1, 1'b1, 32'd5000);
        send_vector(0, 0, 16384, 1'b1, 32'd5200);
        send_vector(0, 0, 16384, 1'b1, 32'd5500);
        send_vector(200, 0, 16384, 1'b1, 32'd6000);
        send_vector(0, 0, 16384, 1'b1, 32'd6001);
        send_vector(0, 0, -32768, 1'b1, 32'd6100);
        send_vector(0, 5, 0, 1'b1, 32'd11001);
        send_vector(-1, 32767, -32768, 1'b0, 32'hFFFF_FFFF);
        send_vector(32767, 32767, 1, 1'b1, 32'd11600);
        send_vector(-32768, -32768, -32768, 1'b1, 32'd12100);
        send_vector(32767, 32767, 32767, 1'b1, 32'd12700);
        send_vector(-20000, 0, 100, 1'b1, 32'hFFFF_FF00);
        send_vector(-20000, 0, 100, 1'b1, 32'h0000_0010);
        send_vector(1, 0, 0, 1'b1, 32'h0000_0020);
        send_vector(0, 0, 0, 1'b1, 32'h0000_0100);
        tick_now = 32'h0000_0100;
    endtask

    task automatic test_default_traffic();
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        run_random_traffic(150);
    endtask

    // Data wider than a register must be cut to the register width.
    task automatic test_register_maxima();
        settle_idle();
        write_reg(REG_TURN_TAN_SQ, 20'hFFFFF);
        write_reg(REG_CENTRE_TAN_SQ, 20'h3FFFF);
        write_reg(REG_FALL_TAN_SQ, 20'hFFFFF);
        write_reg(REG_BLINK_TICKS, 20'hFFFFF);
        write_reg(REG_COOLDOWN_TICKS, 20'hFFFFF);
        write_reg(REG_SHOT_SPACING, 20'h1FFFF);
        write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_7, '0);
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b0;
        run_random_traffic(80);
    endtask

    task automatic test_register_zeros();
        settle_idle();
        write_reg(REG_TURN_TAN_SQ, '0);
        write_reg(REG_CENTRE_TAN_SQ, '0);
        write_reg(REG_FALL_TAN_SQ, '0);
        write_reg(REG_BLINK_TICKS, '0);
        write_reg(REG_COOLDOWN_TICKS, '0);
        write_reg(REG_SHOT_SPACING, '0);
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b1;
        tick_now    = tick_now + 32'd10;
        send_vector(0, 0, 0, 1'b1, tick_now);
        run_random_traffic(80);
    endtask

    // At 45 degrees every threshold sits exactly on the vector, and each test is strict.
    task automatic test_threshold_equality();
        settle_idle();
        write_reg(REG_TURN_TAN_SQ, 20'd65536);
        write_reg(REG_CENTRE_TAN_SQ, 20'd65536);
        write_reg(REG_FALL_TAN_SQ, 20'd65536);
        write_reg(REG_BLINK_TICKS, 20'd1);
        write_reg(REG_COOLDOWN_TICKS, 20'd1);
        write_reg(REG_SHOT_SPACING, 20'd1);
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        tick_now    = tick_now + 32'd100;
        send_vector(100, 0, 100, 1'b1, tick_now);
        send_vector(-100, 0, 100, 1'b1, tick_now + 32'd1);
        send_vector(-3, 4, 5, 1'b1, tick_now + 32'd2);
        tick_now = tick_now + 32'd2;
        run_random_traffic(60);
    endtask

    task automatic test_random_registers();
        int turn;
        repeat (2) begin
            settle_idle();
            turn = $urandom_range(0, 200000);
            write_reg(REG_TURN_TAN_SQ, CFG_DATA_W'(turn));
            write_reg(REG_CENTRE_TAN_SQ, CFG_DATA_W'($urandom_range(0, turn)));
            write_reg(REG_FALL_TAN_SQ, CFG_DATA_W'($urandom_range(0, 262143)));
            write_reg(REG_BLINK_TICKS, CFG_DATA_W'($urandom_range(1, 300)));
            write_reg(REG_COOLDOWN_TICKS, CFG_DATA_W'($urandom_range(0, 3000)));
            write_reg(REG_SHOT_SPACING, CFG_DATA_W'($urandom_range(0, 400)));
            tx_gap_en   = 1'b1;
            rx_stall_en = 1'b1;
            run_random_traffic(100);
        end
    endtask

    // Disabling is permanent, so this runs last. The run started here is frozen
    // by the disable and must keep reporting busy.
    task automatic test_failed_reads_disable();
        settle_idle();
        write_reg(REG_FALL_TAN_SQ, 20'd65536);
        write_reg(REG_COOLDOWN_TICKS, '0);
        write_reg(REG_SHOT_SPACING, 20'd60000);
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        tick_now    = tick_now + 32'd100;
        send_vector(0, 0, -16384, 1'b1, tick_now);
        tick_now = tick_now + 32'd100;
        send_vector(0, 0, -16384, 1'b1, tick_now);
        while (!blocked) begin
            tick_now = tick_now + 32'd5;
            send_vector($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), 1'b0, tick_now);
            idle_sender(idle_length(tx_gap_en));
        end
        run_random_traffic(40);
    endtask

    initial begin : result_ready_driver
        int stall_left;
        stall_left     = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                result_if.ready = 1'b0;
                stall_left--;
            end else begin
                result_if.ready = 1'b1;
                stall_left = idle_length(rx_stall_en);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_if.valid && result_if.ready) begin
            got_status = '{result_if.left_lamp, result_if.right_lamp, result_if.fall_signal,
                           result_if.capture_busy, result_if.sensor_disabled};
            if (expected_status_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTED) begin
                    $display("unexpected result word %b with nothing outstanding", got_status);
                end
            end else begin
                want_status = expected_status_q.pop_front();
                if (got_status !== want_status) begin
                    error_count++;
                    if (error_count <= MAX_REPORTED) begin
                        $display("mismatch at %0t: left/right/fall/busy/disabled %b, got %b",
                                 $realtime, want_status, got_status);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = '0;
        cfg_wdata              = '0;
        sample_if.valid        = 1'b0;
        sample_if.accel_x      = '0;
        sample_if.accel_y      = '0;
        sample_if.accel_z      = '0;
        sample_if.sample_valid = 1'b0;
        sample_if.now_ticks    = '0;
        tx_gap_en              = 1'b0;
        rx_stall_en            = 1'b0;
        tick_now               = '0;

        cfg_shadow.turn_tan_sq        = RST_TURN_TAN_SQ;
        cfg_shadow.centre_tan_sq      = RST_CENTRE_TAN_SQ;
        cfg_shadow.fall_tan_sq        = RST_FALL_TAN_SQ;
        cfg_shadow.blink_ticks        = RST_BLINK_TICKS;
        cfg_shadow.cooldown_ticks     = RST_COOLDOWN;
        cfg_shadow.shot_spacing_ticks = RST_SHOT_SPACING;
        left_armed    = 1'b0;
        right_armed   = 1'b0;
        blink_phase   = 1'b0;
        left_level    = 1'b0;
        right_level   = 1'b0;
        last_toggle   = '0;
        capturing     = 1'b0;
        shots_done    = '0;
        capture_start = '0;
        capture_end   = '0;
        failed_reads  = '0;
        blocked       = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_default_traffic();
        test_register_maxima();
        test_register_zeros();
        test_threshold_equality();
        test_random_registers();
        test_failed_reads_disable();
        settle_idle();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
